[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form of the clocked assertion
`define ASSERT_IMPLY(label, pre, post, msg) \
	`ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

[hdl/rlfe_pkg.sv]
// types, constants and helper functions of the region line feature extractor
package rlfe_pkg;

	localparam int REGION_SIZE  = 7;
	localparam int GRID_SIDE    = 3;
	localparam int GRID_EXTENT  = REGION_SIZE * GRID_SIDE;
	localparam int NUM_REGIONS  = GRID_SIDE * GRID_SIDE;
	localparam int NUM_PATTERNS = 4;
	localparam int FEAT_W       = NUM_PATTERNS * NUM_REGIONS;
	localparam int CNT_W        = $clog2(FEAT_W + 1);
	localparam int RED_W        = 8;
	localparam int WIDTH_W      = 13;
	localparam int POS_W        = 12;
	localparam int COL_IDX_W    = $clog2(GRID_EXTENT);
	localparam int BLK_W        = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int REG_IDX_W    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam int WIN_W        = 9;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd21;
	localparam logic [POS_W-1:0]   POS_MAX     = {POS_W{1'b1}};

	// pattern codes within one region's nibble
	localparam int PAT_VERT  = 0;
	localparam int PAT_HORIZ = 1;
	localparam int PAT_DIAG  = 2;
	localparam int PAT_ANTI  = 3;

	typedef struct packed {
		logic [RED_W-1:0] red_level;
		logic             last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [FEAT_W-1:0] feature_bits;
		logic [CNT_W-1:0]  ones_count;
	} result_t;

	// finished feature vector waiting for the output stage
	typedef struct packed {
		logic              valid;
		logic [FEAT_W-1:0] features;
	} frame_t;

	// region block of a grid coordinate
	function automatic logic [BLK_W-1:0] block_of(input logic [COL_IDX_W-1:0] p);
		logic [BLK_W-1:0] blk;
		blk = '0;
		for (int b = 1; b < GRID_SIDE; b++) begin
			if (int'(p) >= b * REGION_SIZE) begin
				blk = BLK_W'(b);
			end
		end
		return blk;
	endfunction

	// true when the coordinate is at least two steps into its region
	function automatic logic offset_ok(input logic [COL_IDX_W-1:0] p,
			input logic [BLK_W-1:0] blk);
		return (int'(p) - int'(blk) * REGION_SIZE) >= 2;
	endfunction

	function automatic logic [CNT_W-1:0] popcount(input logic [FEAT_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < FEAT_W; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

[hdl/rlfe_window.sv]
// line buffers, 3x3 window, position tracking, pattern match and accumulator
module rlfe_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rlfe_pkg::WIDTH_W-1:0]  image_width,
	input  logic                          take,
	input  rlfe_pkg::pixel_t              px,
	input  logic                          frame_pop,
	output rlfe_pkg::frame_t              frame_s1
);
	import rlfe_pkg::*;

	logic [GRID_EXTENT-1:0] above_q;
	logic [GRID_EXTENT-1:0] two_above_q;
	logic [WIN_W-1:0]       win_q;
	logic [POS_W-1:0]       col_q;
	logic [POS_W-1:0]       row_q;
	logic [FEAT_W-1:0]      acc_q;
	logic                   valid_s1;
	logic [FEAT_W-1:0]      features_s1;

	logic                   in_col;
	logic                   in_row;
	logic [COL_IDX_W-1:0]   cidx;
	logic [COL_IDX_W-1:0]   ridx;
	logic                   px_set;
	logic                   above;
	logic                   two_above;
	logic [WIN_W-1:0]       win_next;
	logic [BLK_W-1:0]       cblk;
	logic [BLK_W-1:0]       rblk;
	logic                   cok;
	logic                   rok;
	logic [NUM_PATTERNS-1:0] pat;
	logic [REG_IDX_W-1:0]   region;
	logic [FEAT_W-1:0]      acc_next;
	logic                   wrap;

	always_comb begin
		in_col    = col_q < POS_W'(GRID_EXTENT);
		in_row    = row_q < POS_W'(GRID_EXTENT);
		cidx      = col_q[COL_IDX_W-1:0];
		ridx      = row_q[COL_IDX_W-1:0];
		px_set    = (px.red_level == '0);
		above     = in_col ? above_q[cidx] : 1'b0;
		two_above = in_col ? two_above_q[cidx] : 1'b0;
		// newest column enters at the top bits, oldest drops out
		win_next  = {px_set, above, two_above, win_q[WIN_W-1:3]};
		cblk      = block_of(cidx);
		rblk      = block_of(ridx);
		cok       = offset_ok(cidx, cblk);
		rok       = offset_ok(ridx, rblk);
		region    = REG_IDX_W'(int'(rblk) * GRID_SIDE + int'(cblk));

		pat = '0;
		pat[PAT_VERT]  = rok && win_next[6] && win_next[7] && win_next[8];
		pat[PAT_HORIZ] = cok && win_next[2] && win_next[5] && win_next[8];
		pat[PAT_DIAG]  = rok && cok && win_next[0] && win_next[4] && win_next[8];
		pat[PAT_ANTI]  = rok && cok && win_next[2] && win_next[4] && win_next[6];

		acc_next = acc_q;
		for (int g = 0; g < NUM_REGIONS; g++) begin
			if (in_col && in_row && (region == REG_IDX_W'(g))) begin
				acc_next[g*NUM_PATTERNS +: NUM_PATTERNS] =
					acc_q[g*NUM_PATTERNS +: NUM_PATTERNS] | pat;
			end
		end

		wrap = ({1'b0, col_q} + WIDTH_W'(1) >= image_width) || (col_q == POS_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q     <= '0;
			two_above_q <= '0;
			win_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			acc_q       <= '0;
		end else if (take) begin
			if (px.last_pixel) begin
				above_q     <= '0;
				two_above_q <= '0;
				win_q       <= '0;
				col_q       <= '0;
				row_q       <= '0;
				acc_q       <= '0;
			end else begin
				if (in_col) begin
					above_q[cidx]     <= px_set;
					two_above_q[cidx] <= above;
				end
				win_q <= win_next;
				acc_q <= acc_next;
				if (wrap) begin
					col_q <= '0;
					if (row_q != POS_MAX) begin
						row_q <= row_q + POS_W'(1);
					end
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	// finished vector holds here until the output stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take && px.last_pixel) begin
			valid_s1 <= 1'b1;
		end else if (frame_pop) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && px.last_pixel) begin
			features_s1 <= acc_next;
		end
	end

	assign frame_s1 = '{valid: valid_s1, features: features_s1};

endmodule

[hdl/rlfe_count.sv]
// output stage: popcount of the feature vector and the result register
module rlfe_count (
	input  logic              clk,
	input  logic              arst_n,
	input  rlfe_pkg::frame_t  frame_s1,
	output logic              frame_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output rlfe_pkg::result_t out_data
);
	import rlfe_pkg::*;

	logic valid_q;

	assign frame_pop = frame_s1.valid && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (frame_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_pop) begin
			out_data.feature_bits <= frame_s1.features;
			out_data.ones_count   <= popcount(frame_s1.features);
		end
	end

endmodule

[hdl/region_line_feature_extractor_unit.sv]
// Region line feature extractor, top level.
// Pixels arrive on the in channel (valid/ready), one red level per transfer in
// raster order; a red level of zero is an ink pixel. The 21x21 top-left area
// is split into a 3x3 grid of 7x7 regions and four line patterns (vertical,
// horizontal, diagonal, anti-diagonal) are tracked per region.
// The transfer that carries last_pixel produces one result on the out channel:
// the 36-bit feature vector and its popcount. Other pixels produce nothing.
// Throughput: one pixel per cycle while in_ready is high. The result path
// is registered: the vector register loads at the last pixel's transfer, then
// the result register loads the vector and its popcount, and out_valid rises.
// image_width is loaded from cfg_wdata when cfg_we is high; write it only
// while no image is in flight. Reset clears all image state and sets the
// width to 21.
// When the receiver stalls, one finished vector waits in the vector register
// behind the result register; while both are full in_ready stays low, for
// any pixel, until the receiver takes the pending result.
module region_line_feature_extractor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rlfe_pkg::WIDTH_W-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rlfe_pkg::pixel_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rlfe_pkg::result_t              out_data
);
	import rlfe_pkg::*;

	logic [WIDTH_W-1:0] image_width_q;
	frame_t             frame_s1;
	logic               frame_pop;
	logic               take;

	assign in_ready = !frame_s1.valid || frame_pop;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			image_width_q <= cfg_wdata;
		end
	end

	rlfe_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (image_width_q),
		.take        (take),
		.px          (in_data),
		.frame_pop   (frame_pop),
		.frame_s1    (frame_s1)
	);

	rlfe_count u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_s1  (frame_s1),
		.frame_pop (frame_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hdl/rlfe_checker.sv]
// port-level checker for the region line feature extractor, with its bind
`include "assert_macros.svh"

module rlfe_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rlfe_pkg::WIDTH_W-1:0]   cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  rlfe_pkg::pixel_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  rlfe_pkg::result_t              out_data
);
	import rlfe_pkg::*;

	// count field always agrees with the vector it travels with
	`ASSERT_IMPLY(a_count_matches, out_valid,
		$countones(out_data.feature_bits) == int'(out_data.ones_count),
		"ones_count does not match feature_bits")

	// a new result rises only after a last-pixel transfer, through the vector register
	`ASSERT_IMPLY(a_result_source, $rose(out_valid),
		$past(in_valid && in_ready && in_data.last_pixel, 2),
		"result without a last-pixel transfer")

	// input only backs up when a result is stuck at the output
	`ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready,
		"in_ready low without output backpressure")

	// a stalled result holds its payload
	`ASSERT_IMPLY(a_out_hold, $past(out_valid && !out_ready),
		out_valid && $stable(out_data),
		"stalled result changed")

endmodule

bind region_line_feature_extractor_unit rlfe_checker u_rlfe_checker (.*);

[verif/region_line_feature_extractor_unit_tb.sv]
// self-checking testbench for the region line feature extractor unit
`timescale 1ns / 100ps

module region_line_feature_extractor_unit_tb;
	import rlfe_pkg::*;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int OUT_HOLD_CYCLES = 300;
	localparam int DIR_ROWS       = 20;
	localparam int STALL_IMAGES   = 30;
	localparam int RANDOM_UNTIL   = 300;
	localparam int PHASE_ITEMS    = 85;
	localparam int MAX_IMAGE      = 60;

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic [RED_W-1:0]   red;
		logic               last;
		logic               typed;
		logic [FEAT_W-1:0]  feat;
		logic [CNT_W-1:0]   cnt;
	} dir_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [WIDTH_W-1:0]  cfg_wdata = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	pixel_t              in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	result_t             out_data;

	// feature tracker state, mirrors the block
	logic [GRID_EXTENT-1:0] trk_above;
	logic [GRID_EXTENT-1:0] trk_two_above;
	logic [WIN_W-1:0]       trk_window;
	logic [POS_W-1:0]       trk_col;
	logic [POS_W-1:0]       trk_row;
	logic [FEAT_W-1:0]      trk_features;
	logic [WIDTH_W-1:0]     trk_width;

	result_t features_due [$];
	result_t due_head;
	int      fail_count  = 0;
	int      cycle_count = 0;
	int      tx_idle_pct = 0;
	int      rx_idle_pct = 0;
	bit      hold_out_req = 1'b0;

	// two one-pixel images, then 3x3 all ink, then 3x3 corners only with an unset centre
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{13'd21, 8'd255, 1'b1, 1'b1, 36'h0, 6'd0},
		'{13'd21, 8'd0,   1'b1, 1'b1, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b1, 1'b1, 36'hF, 6'd4},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd1,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd255, 1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd1,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd128, 1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd254, 1'b0, 1'b0, 36'h0, 6'd0},
		'{13'd3,  8'd0,   1'b1, 1'b1, 36'h0, 6'd0}
	};

	region_line_feature_extractor_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic clear_tracker();
		trk_above     = '0;
		trk_two_above = '0;
		trk_window    = '0;
		trk_col       = '0;
		trk_row       = '0;
		trk_features  = '0;
	endtask

	// advance the tracker by one pixel; returns the finished vector on the last pixel
	task automatic track_pixel(input pixel_t px, output bit done, output result_t res);
		int         c;
		int         r;
		int         region;
		logic       ink;
		logic       a;
		logic       ta;
		logic       rok;
		logic       cok;
		logic [3:0] pat;
		c   = int'(trk_col);
		r   = int'(trk_row);
		ink = (px.red_level == '0);
		a   = 1'b0;
		ta  = 1'b0;
		res = '0;
		if (c < GRID_EXTENT) begin
			a  = trk_above[c];
			ta = trk_two_above[c];
			trk_two_above[c] = a;
			trk_above[c]     = ink;
		end
		// window bit 3*dc+dr, newest column on top
		trk_window = {ink, a, ta, trk_window[WIN_W-1:3]};
		if (c < GRID_EXTENT && r < GRID_EXTENT) begin
			rok    = (r % REGION_SIZE) >= 2;
			cok    = (c % REGION_SIZE) >= 2;
			region = (r / REGION_SIZE) * GRID_SIDE + c / REGION_SIZE;
			pat    = '0;
			if (rok && trk_window[6] && trk_window[7] && trk_window[8])
				pat[PAT_VERT] = 1'b1;
			if (cok && trk_window[2] && trk_window[5] && trk_window[8])
				pat[PAT_HORIZ] = 1'b1;
			if (rok && cok && trk_window[0] && trk_window[4] && trk_window[8])
				pat[PAT_DIAG] = 1'b1;
			if (rok && cok && trk_window[2] && trk_window[4] && trk_window[6])
				pat[PAT_ANTI] = 1'b1;
			trk_features |= FEAT_W'(pat) << (NUM_PATTERNS * region);
		end
		if (c + 1 >= int'(trk_width) || c >= int'(POS_MAX)) begin
			trk_col = '0;
			if (trk_row < POS_MAX)
				trk_row = trk_row + 1'b1;
		end else begin
			trk_col = trk_col + 1'b1;
		end
		done = px.last_pixel;
		if (done) begin
			res.feature_bits = trk_features;
			res.ones_count   = CNT_W'($countones(trk_features));
			clear_tracker();
		end
	endtask

	task automatic send_pixel(input pixel_t px, input bit typed, input result_t typed_res);
		bit      done;
		result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		track_pixel(px, done, res);
		if (done)
			features_due.push_back(typed ? typed_res : res);
	endtask

	function automatic logic [RED_W-1:0] pick_red(input int ink_pct);
		if ($urandom_range(99) < ink_pct)
			return '0;
		case ($urandom_range(9))
			0: return '1;
			1: return RED_W'(1);
			default: return RED_W'($urandom_range(1, 255));
		endcase
	endfunction

	// n pixels, the last one closing the image
	task automatic send_image(input int n, input int grid_ink_pct, input int outside_ink_pct);
		pixel_t px;
		bit     in_grid;
		for (int i = 0; i < n; i++) begin
			in_grid       = trk_col < GRID_EXTENT && trk_row < GRID_EXTENT;
			px.red_level  = pick_red(in_grid ? grid_ink_pct : outside_ink_pct);
			px.last_pixel = (i == n - 1);
			send_pixel(px, 1'b0, '0);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (features_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input int w);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= WIDTH_W'(w);
		@(posedge clk);
		cfg_we    <= 1'b0;
		trk_width = WIDTH_W'(w);
	endtask

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_out_req) begin
				out_ready <= 1'b0;
				repeat (OUT_HOLD_CYCLES - 1) @(posedge clk);
				hold_out_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (features_due.size() == 0) begin
				$error("unexpected result: feature_bits %h ones_count %0d",
					out_data.feature_bits, out_data.ones_count);
				fail_count++;
			end else begin
				due_head = features_due.pop_front();
				if (out_data.feature_bits !== due_head.feature_bits) begin
					$error("feature_bits: expected %h, actual %h",
						due_head.feature_bits, out_data.feature_bits);
					fail_count++;
				end
				if (out_data.ones_count !== due_head.ones_count) begin
					$error("ones_count: expected %0d, actual %0d",
						due_head.ones_count, out_data.ones_count);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int      item_count;
		int      loop_items;
		int      n;
		int      eff;
		int      w;
		pixel_t  px;
		result_t typed_res;
		item_count = 0;
		loop_items = 0;
		clear_tracker();
		trk_width = WIDTH_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 30;
		rx_idle_pct = 70;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].width != trk_width)
				write_width(int'(directed_rows[i].width));
			px.red_level           = directed_rows[i].red;
			px.last_pixel          = directed_rows[i].last;
			typed_res.feature_bits = directed_rows[i].feat;
			typed_res.ones_count   = directed_rows[i].cnt;
			send_pixel(px, directed_rows[i].typed, typed_res);
		end
		item_count += DIR_ROWS;

		// long output stall with one-pixel images: buffer fills, input backs up
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		hold_out_req = 1'b1;
		for (int i = 0; i < STALL_IMAGES; i++) begin
			px.red_level  = pick_red(50);
			px.last_pixel = 1'b1;
			send_pixel(px, 1'b0, '0);
		end
		item_count += STALL_IMAGES;
		wait_idle();

		while (item_count < RANDOM_UNTIL) begin
			case (loop_items / PHASE_ITEMS)
				0: begin
					tx_idle_pct = 30;
					rx_idle_pct = 70;
				end
				1: begin
					tx_idle_pct = 70;
					rx_idle_pct = 30;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0: w = $urandom_range(0, 2);
					1, 2, 3, 4, 5, 6: w = $urandom_range(3, 21);
					default: w = $urandom_range(22, 40);
				endcase
				write_width(w);
			end
			eff = (trk_width <= 1) ? 1 : int'(trk_width);
			n = eff * $urandom_range(1, 24);
			if (trk_width <= 1)
				n = $urandom_range(1, 30);
			if (n > MAX_IMAGE)
				n = MAX_IMAGE;
			if ($urandom_range(7) == 0)
				n = $urandom_range(1, n);
			if ($urandom_range(9) == 0)
				n = 1;
			send_image(n, $urandom_range(20, 95), 20);
			item_count += n;
			loop_items += n;
		end

		// width extremes
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_width(4096);
		send_image(30, 60, 2);
		write_width(8191);
		send_image(30, 60, 2);
		write_width(1);
		send_image(20, 60, 60);
		write_width(0);
		send_image(20, 60, 60);

		wait_idle();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
